>>> hdl/mta_pkg.sv
// Package with the constants, types and helpers shared by the mosaic tile averager.
package mta_pkg;

	localparam int MaxWidth  = 2048;
	localparam int MaxHeight = 2048;
	localparam int MaxTile   = 64;

	localparam int PosW   = $clog2(MaxWidth);
	localparam int RowW   = $clog2(MaxHeight);
	localparam int OffW   = $clog2(MaxTile);
	localparam int TileW  = 7;
	localparam int DimW   = 12;
	localparam int SumW   = 20;
	localparam int CountW = 2 * (OffW + 1);
	localparam int AddrW  = 4;

	localparam logic [AddrW-1:0] RegImageWidth  = 4'h0;
	localparam logic [AddrW-1:0] RegImageHeight = 4'h4;
	localparam logic [AddrW-1:0] RegTileSize    = 4'h8;

	typedef struct packed {
		logic [SumW-1:0] blue;
		logic [SumW-1:0] green;
		logic [SumW-1:0] red;
	} sums_t;

	typedef struct packed {
		sums_t           sums;
		logic [CountW-1:0] count;
		logic [PosW-1:0] column;
		logic [RowW-1:0] row;
		logic            done;
	} job_t;

	typedef struct packed {
		logic [7:0]      blue;
		logic [7:0]      green;
		logic [7:0]      red;
		logic [PosW-1:0] column;
		logic [RowW-1:0] row;
		logic            done;
	} tile_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_OUT
	} div_state_t;

endpackage

>>> hdl/mta_if.sv
// Valid and ready channel interfaces for pixels and finished tiles.
interface mta_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_blue;
	logic [7:0] pixel_green;
	logic [7:0] pixel_red;
	modport source (output valid, pixel_blue, pixel_green, pixel_red, input ready);
	modport sink (input valid, pixel_blue, pixel_green, pixel_red, output ready);
endinterface

interface mta_tile_if;
	logic        valid;
	logic        ready;
	logic [7:0]  avg_blue;
	logic [7:0]  avg_green;
	logic [7:0]  avg_red;
	logic [10:0] tile_column;
	logic [10:0] tile_row;
	logic        image_done;
	modport source (output valid, avg_blue, avg_green, avg_red, tile_column, tile_row,
		image_done, input ready);
	modport sink (input valid, avg_blue, avg_green, avg_red, tile_column, tile_row,
		image_done, output ready);
endinterface

>>> hdl/mosaic_tile_averager_unit.sv
// Top level of the mosaic tile averager with its configuration registers.
//
//   channel   | direction | transaction
//   pixel_in  | sink      | one BGR pixel in raster order
//   tile_out  | source    | mean colour and coordinates of a finished tile
//   apb       | slave     | register write or read
//
// Pixels are taken one per clock while the tile queue has room. Each finished
// tile holds the shared divider for a load step, twenty shift steps and a step
// to present the result. Tiles finish only on the last row of a band, one every
// tile_size pixels, so on that row the pixel input stalls once the queue fills
// whenever tiles finish faster than the divider takes them; other rows take one pixel per clock.
// Reset and a write to any of the three registers restart the image at its first pixel.
// A stalled output fills the queue and then holds the pixel input.
module mosaic_tile_averager_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	mta_pixel_if.sink                 pixel_in,
	mta_tile_if.source                tile_out,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [mta_pkg::AddrW-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);
	import mta_pkg::*;

	logic [DimW-1:0]  width_q;
	logic [DimW-1:0]  height_q;
	logic [TileW-1:0] tile_q;
	logic             wr_en;
	logic             restart;
	logic             fj_valid;
	job_t             fj;
	logic             room;
	logic             qj_valid;
	job_t             qj;
	logic             qj_ready;
	logic             r_valid;
	tile_t            r;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign restart = wr_en && (paddr == RegImageWidth || paddr == RegImageHeight
		|| paddr == RegTileSize);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DimW'(640);
			height_q <= DimW'(480);
			tile_q   <= TileW'(8);
		end else if (wr_en) begin
			unique case (paddr)
				RegImageWidth:  width_q  <= pwdata[DimW-1:0];
				RegImageHeight: height_q <= pwdata[DimW-1:0];
				RegTileSize:    tile_q   <= pwdata[TileW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			RegImageWidth:  prdata = 32'(width_q);
			RegImageHeight: prdata = 32'(height_q);
			RegTileSize:    prdata = 32'(tile_q);
			default:        prdata = '0;
		endcase
	end

	mta_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (restart),
		.width_cfg  (width_q),
		.height_cfg (height_q),
		.tile_cfg   (tile_q),
		.in_valid   (pixel_in.valid),
		.in_blue    (pixel_in.pixel_blue),
		.in_green   (pixel_in.pixel_green),
		.in_red     (pixel_in.pixel_red),
		.in_ready   (pixel_in.ready),
		.job_valid  (fj_valid),
		.job        (fj),
		.job_room   (room)
	);

	mta_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fj_valid),
		.in_job    (fj),
		.room      (room),
		.out_valid (qj_valid),
		.out_job   (qj),
		.out_ready (qj_ready)
	);

	mta_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (qj_valid),
		.job       (qj),
		.job_ready (qj_ready),
		.res_valid (r_valid),
		.res       (r),
		.res_ready (tile_out.ready)
	);

	assign tile_out.valid       = r_valid;
	assign tile_out.avg_blue    = r.blue;
	assign tile_out.avg_green   = r.green;
	assign tile_out.avg_red     = r.red;
	assign tile_out.tile_column = r.column;
	assign tile_out.tile_row    = r.row;
	assign tile_out.image_done  = r.done;
endmodule

>>> hdl/mta_front.sv
// Front end: pixel counters, column sum memory and tile completion detection.
module mta_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    restart,
	input  logic [mta_pkg::DimW-1:0]  width_cfg,
	input  logic [mta_pkg::DimW-1:0]  height_cfg,
	input  logic [mta_pkg::TileW-1:0] tile_cfg,
	input  logic                    in_valid,
	input  logic [7:0]              in_blue,
	input  logic [7:0]              in_green,
	input  logic [7:0]              in_red,
	output logic                    in_ready,
	output logic                    job_valid,
	output mta_pkg::job_t           job,
	input  logic                    job_room
);
	import mta_pkg::*;

	logic [DimW-1:0]  w;
	logic [DimW-1:0]  h;
	logic [OffW:0]    t;
	logic [PosW-1:0]  x_q;
	logic [RowW-1:0]  y_q;
	logic [OffW-1:0]  xt_q;
	logic [OffW-1:0]  yt_q;
	logic [PosW-1:0]  tx_q;
	logic [RowW-1:0]  ty_q;
	logic             last_x;
	logic             last_y;
	logic             end_x;
	logic             end_y;
	logic             fire;

	// Stage one holds the pixel and its memory address while the entry is read.
	logic             v_s1;
	logic [7:0]       b_s1;
	logic [7:0]       g_s1;
	logic [7:0]       r_s1;
	logic             first_s1;
	logic             emit_s1;
	logic [PosW-1:0]  col_s1;
	logic [RowW-1:0]  row_s1;
	logic             done_s1;
	logic [CountW-1:0] count_s1;
	sums_t            rd_s1;

	// Bypass of the last write, for the same column read again next cycle.
	logic             byp_v_q;
	logic [PosW-1:0]  byp_col_q;
	sums_t            byp_q;
	sums_t            old_sums;
	sums_t            new_sums;

	sums_t            mem [MaxWidth];

	always_comb begin
		if (width_cfg == '0) begin
			w = DimW'(1);
		end else if (width_cfg > DimW'(MaxWidth)) begin
			w = DimW'(MaxWidth);
		end else begin
			w = width_cfg;
		end
		if (height_cfg == '0) begin
			h = DimW'(1);
		end else if (height_cfg > DimW'(MaxHeight)) begin
			h = DimW'(MaxHeight);
		end else begin
			h = height_cfg;
		end
		if (tile_cfg == '0) begin
			t = (OffW+1)'(1);
		end else if (tile_cfg > TileW'(MaxTile)) begin
			t = (OffW+1)'(MaxTile);
		end else begin
			t = (OffW+1)'(tile_cfg);
		end
	end

	assign in_ready = job_room;
	assign fire = in_valid && in_ready;
	assign last_x = ({1'b0, x_q} == w - DimW'(1));
	assign last_y = ({1'b0, y_q} == h - DimW'(1));
	assign end_x = last_x || ({1'b0, xt_q} + (OffW+1)'(1) == t);
	assign end_y = last_y || ({1'b0, yt_q} + (OffW+1)'(1) == t);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q  <= '0;
			y_q  <= '0;
			xt_q <= '0;
			yt_q <= '0;
			tx_q <= '0;
			ty_q <= '0;
		end else if (restart) begin
			x_q  <= '0;
			y_q  <= '0;
			xt_q <= '0;
			yt_q <= '0;
			tx_q <= '0;
			ty_q <= '0;
		end else if (fire) begin
			if (last_x) begin
				x_q  <= '0;
				xt_q <= '0;
				tx_q <= '0;
				if (last_y) begin
					y_q  <= '0;
					yt_q <= '0;
					ty_q <= '0;
				end else begin
					y_q <= y_q + RowW'(1);
					if (end_y) begin
						yt_q <= '0;
						ty_q <= ty_q + RowW'(1);
					end else begin
						yt_q <= yt_q + OffW'(1);
					end
				end
			end else begin
				x_q <= x_q + PosW'(1);
				if (end_x) begin
					xt_q <= '0;
					tx_q <= tx_q + PosW'(1);
				end else begin
					xt_q <= xt_q + OffW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			byp_v_q <= 1'b0;
		end else begin
			v_s1    <= fire && !restart;
			byp_v_q <= v_s1 && !restart;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			b_s1     <= in_blue;
			g_s1     <= in_green;
			r_s1     <= in_red;
			first_s1 <= (xt_q == '0) && (yt_q == '0);
			emit_s1  <= end_x && end_y;
			col_s1   <= tx_q;
			row_s1   <= ty_q;
			done_s1  <= last_x && last_y;
			count_s1 <= CountW'(({1'b0, xt_q} + (OffW+1)'(1)))
				* CountW'(({1'b0, yt_q} + (OffW+1)'(1)));
		end
	end

	always_ff @(posedge clk) begin
		rd_s1 <= mem[tx_q];
	end

	always_comb begin
		old_sums = (byp_v_q && byp_col_q == col_s1) ? byp_q : rd_s1;
		if (first_s1) begin
			new_sums.blue  = SumW'(b_s1);
			new_sums.green = SumW'(g_s1);
			new_sums.red   = SumW'(r_s1);
		end else begin
			new_sums.blue  = old_sums.blue + SumW'(b_s1);
			new_sums.green = old_sums.green + SumW'(g_s1);
			new_sums.red   = old_sums.red + SumW'(r_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			mem[col_s1] <= new_sums;
			byp_q       <= new_sums;
			byp_col_q   <= col_s1;
		end
	end

	assign job_valid  = v_s1 && emit_s1;
	assign job.sums   = new_sums;
	assign job.count  = count_s1;
	assign job.column = col_s1;
	assign job.row    = row_s1;
	assign job.done   = done_s1;
endmodule

>>> hdl/mta_queue.sv
// Short queue of tile jobs between the front end and the divider.
module mta_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  mta_pkg::job_t in_job,
	output logic          room,
	output logic          out_valid,
	output mta_pkg::job_t out_job,
	input  logic          out_ready
);
	import mta_pkg::*;

	localparam int Depth = 4;

	job_t        slots_q [Depth];
	logic [1:0]  wr_q;
	logic [1:0]  rd_q;
	logic [2:0]  cnt_q;
	logic        push;
	logic        pop;

	// One pixel may be in flight, so a free slot is kept for it.
	assign room      = cnt_q < 3'(Depth - 1);
	assign out_valid = cnt_q != '0;
	assign out_job   = slots_q[rd_q];
	assign push      = in_valid;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 2'd1;
			end
			if (pop) begin
				rd_q <= rd_q + 2'd1;
			end
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= in_job;
		end
	end
endmodule

>>> hdl/mta_divider.sv
// Back end: restoring divider that forms the three channel means of a tile.
module mta_divider (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	input  mta_pkg::job_t job,
	output logic          job_ready,
	output logic          res_valid,
	output mta_pkg::tile_t res,
	input  logic          res_ready
);
	import mta_pkg::*;

	localparam int StepW = $clog2(SumW + 1);

	div_state_t       state_q;
	div_state_t       state_d;
	logic [StepW-1:0] step_q;
	logic [SumW-1:0]  qb_q;
	logic [SumW-1:0]  qg_q;
	logic [SumW-1:0]  qr_q;
	logic [CountW:0]  rb_q;
	logic [CountW:0]  rg_q;
	logic [CountW:0]  rr_q;
	logic [CountW:0]  tb;
	logic [CountW:0]  tg;
	logic [CountW:0]  tr;
	logic [CountW:0]  div_q;
	logic [PosW-1:0]  col_q;
	logic [RowW-1:0]  row_q;
	logic             done_q;
	logic             load;
	logic             finish;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		job_ready = 1'b0;
		res_valid = 1'b0;
		load      = 1'b0;
		unique case (state_q)
			DIV_IDLE: begin
				job_ready = 1'b1;
				if (job_valid) begin
					load    = 1'b1;
					state_d = DIV_RUN;
				end
			end
			DIV_RUN: begin
				if (step_q == StepW'(SumW - 1)) begin
					state_d = DIV_OUT;
				end
			end
			DIV_OUT: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = DIV_IDLE;
				end
			end
			default: begin
				state_d = DIV_IDLE;
			end
		endcase
	end

	assign finish = state_q == DIV_RUN;
	assign tb = {rb_q[CountW-1:0], qb_q[SumW-1]};
	assign tg = {rg_q[CountW-1:0], qg_q[SumW-1]};
	assign tr = {rr_q[CountW-1:0], qr_q[SumW-1]};

	always_ff @(posedge clk) begin
		if (load) begin
			qb_q   <= job.sums.blue;
			qg_q   <= job.sums.green;
			qr_q   <= job.sums.red;
			rb_q   <= '0;
			rg_q   <= '0;
			rr_q   <= '0;
			div_q  <= {1'b0, job.count};
			col_q  <= job.column;
			row_q  <= job.row;
			done_q <= job.done;
			step_q <= '0;
		end else if (finish) begin
			step_q <= step_q + StepW'(1);
			if (tb >= div_q) begin
				rb_q <= tb - div_q;
				qb_q <= {qb_q[SumW-2:0], 1'b1};
			end else begin
				rb_q <= tb;
				qb_q <= {qb_q[SumW-2:0], 1'b0};
			end
			if (tg >= div_q) begin
				rg_q <= tg - div_q;
				qg_q <= {qg_q[SumW-2:0], 1'b1};
			end else begin
				rg_q <= tg;
				qg_q <= {qg_q[SumW-2:0], 1'b0};
			end
			if (tr >= div_q) begin
				rr_q <= tr - div_q;
				qr_q <= {qr_q[SumW-2:0], 1'b1};
			end else begin
				rr_q <= tr;
				qr_q <= {qr_q[SumW-2:0], 1'b0};
			end
		end
	end

	assign res.blue   = (qb_q > SumW'(255)) ? 8'hFF : qb_q[7:0];
	assign res.green  = (qg_q > SumW'(255)) ? 8'hFF : qg_q[7:0];
	assign res.red    = (qr_q > SumW'(255)) ? 8'hFF : qr_q[7:0];
	assign res.column = col_q;
	assign res.row    = row_q;
	assign res.done   = done_q;
endmodule

>>> tb/mosaic_tile_averager_unit_tb.sv
// Self-checking testbench for the mosaic tile averager: directed table, random frames, APB setup.
module mosaic_tile_averager_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mta_pkg::*;

	localparam logic [AddrW-1:0] RegUnused = 4'hC;

	typedef enum logic {ROW_CFG, ROW_PIX} row_kind_e;

	typedef struct {
		row_kind_e        kind;
		logic [AddrW-1:0] addr;
		logic [31:0]      data;
		logic [7:0]       blue;
		logic [7:0]       green;
		logic [7:0]       red;
		bit               typed;
		tile_t            tile;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [AddrW-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	mta_pixel_if pixel_in ();
	mta_tile_if  tile_out ();

	mosaic_tile_averager_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.pixel_in(pixel_in.sink),
		.tile_out(tile_out.source),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	logic [11:0]     reg_width;
	logic [11:0]     reg_height;
	logic [6:0]      reg_tile;
	logic [SumW-1:0] blue_sums [MaxWidth];
	logic [SumW-1:0] green_sums [MaxWidth];
	logic [SumW-1:0] red_sums [MaxWidth];
	int              x_pos;
	int              y_pos;
	int              x_off;
	int              y_off;
	int              tile_col;

	tile_t     tile_queue [$];
	stim_row_t stim_table [$];
	int        mismatches;
	int        pixels_sent;
	int        tiles_seen;
	int        frames_set;
	bit        stall_on;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	initial begin
		#50ms;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int clamp_dim(int v, int hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic void restart_frame();
		for (int i = 0; i < MaxWidth; i++) begin
			blue_sums[i] = '0;
			green_sums[i] = '0;
			red_sums[i] = '0;
		end
		x_pos = 0;
		y_pos = 0;
		x_off = 0;
		y_off = 0;
		tile_col = 0;
	endfunction

	function automatic bit tile_average(input logic [7:0] b, g, r, output tile_t res);
		int  w;
		int  h;
		int  t;
		int  col;
		int  cnt;
		bit  lx;
		bit  ly;
		bit  ex;
		bit  ey;
		bit  hit;
		w = clamp_dim(int'(reg_width), MaxWidth);
		h = clamp_dim(int'(reg_height), MaxHeight);
		t = clamp_dim(int'(reg_tile), MaxTile);
		hit = 1'b0;
		res = '0;
		if (x_pos >= w || y_pos >= h) restart_frame();
		col = tile_col % MaxWidth;
		if (x_off == 0 && y_off == 0) begin
			blue_sums[col] = SumW'(b);
			green_sums[col] = SumW'(g);
			red_sums[col] = SumW'(r);
		end else begin
			blue_sums[col] = blue_sums[col] + SumW'(b);
			green_sums[col] = green_sums[col] + SumW'(g);
			red_sums[col] = red_sums[col] + SumW'(r);
		end
		lx = (x_pos == w - 1);
		ly = (y_pos == h - 1);
		ex = lx || (x_off + 1 == t);
		ey = ly || (y_off + 1 == t);
		if (ex && ey) begin
			cnt = (x_off + 1) * (y_off + 1);
			res.blue = (blue_sums[col] / cnt > 255) ? 8'd255 : 8'(blue_sums[col] / cnt);
			res.green = (green_sums[col] / cnt > 255) ? 8'd255 : 8'(green_sums[col] / cnt);
			res.red = (red_sums[col] / cnt > 255) ? 8'd255 : 8'(red_sums[col] / cnt);
			res.column = PosW'(tile_col);
			res.row = RowW'(y_pos / t);
			res.done = lx && ly;
			hit = 1'b1;
		end
		if (lx) begin
			x_pos = 0;
			x_off = 0;
			tile_col = 0;
			if (ly) begin
				y_pos = 0;
				y_off = 0;
			end else begin
				y_pos++;
				y_off = ey ? 0 : y_off + 1;
			end
		end else begin
			x_pos++;
			if (ex) begin
				x_off = 0;
				tile_col++;
			end else begin
				x_off++;
			end
		end
		return hit;
	endfunction

	function automatic void add_cfg(logic [AddrW-1:0] a, logic [31:0] d);
		stim_row_t row;
		row = '{kind: ROW_CFG, addr: a, data: d, blue: '0, green: '0, red: '0,
			typed: 1'b0, tile: '0};
		stim_table.push_back(row);
	endfunction

	function automatic void add_pix(logic [7:0] b, g, r, bit typed, tile_t tile);
		stim_row_t row;
		row = '{kind: ROW_PIX, addr: '0, data: '0, blue: b, green: g, red: r,
			typed: typed, tile: tile};
		stim_table.push_back(row);
	endfunction

	function automatic tile_t mk_tile(logic [7:0] b, g, r, int c, int rw, bit d);
		tile_t t;
		t.blue = b;
		t.green = g;
		t.red = r;
		t.column = PosW'(c);
		t.row = RowW'(rw);
		t.done = d;
		return t;
	endfunction

	task automatic wait_drained();
		@(negedge clk);
		pixel_in.valid = 1'b0;
		while (tile_queue.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic apb_access(logic wr, logic [AddrW-1:0] a, logic [31:0] d,
		output logic [31:0] rd);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = a;
		pwdata = d;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic set_reg(logic [AddrW-1:0] a, logic [31:0] d);
		logic [31:0] rd;
		logic [31:0] want;
		wait_drained();
		apb_access(1'b1, a, d, rd);
		case (a)
			RegImageWidth: begin
				reg_width = d[11:0];
				restart_frame();
			end
			RegImageHeight: begin
				reg_height = d[11:0];
				restart_frame();
			end
			RegTileSize: begin
				reg_tile = d[6:0];
				restart_frame();
			end
			default: ;
		endcase
		if (a != RegUnused) begin
			apb_access(1'b0, a, '0, rd);
			want = (a == RegImageWidth) ? {20'd0, reg_width} :
				(a == RegImageHeight) ? {20'd0, reg_height} : {25'd0, reg_tile};
			if (rd !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Register read at %h: expected %h, got %h", a, want, rd);
			end
		end
		frames_set++;
	endtask

	task automatic send_pixel(logic [7:0] b, g, r, bit typed, tile_t tile);
		tile_t res;
		@(negedge clk);
		if (stall_on && $urandom_range(0, 4) == 0) begin
			pixel_in.valid = 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		pixel_in.valid = 1'b1;
		pixel_in.pixel_blue = b;
		pixel_in.pixel_green = g;
		pixel_in.pixel_red = r;
		do @(posedge clk); while (!pixel_in.ready);
		pixels_sent++;
		if (tile_average(b, g, r, res)) tile_queue.push_back(typed ? tile : res);
		else if (typed) tile_queue.push_back(tile);
	endtask

	function automatic logic [7:0] rand_chan();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic random_frame(int w, int h, int t, int n, bit hold_mid);
		set_reg(RegImageWidth, w);
		set_reg(RegImageHeight, h);
		set_reg(RegTileSize, t);
		for (int i = 0; i < n; i++) begin
			if (hold_mid && i == n / 2) begin
				@(negedge clk);
				pixel_in.valid = 1'b0;
				while (tile_queue.size() != 0) @(negedge clk);
			end
			send_pixel(rand_chan(), rand_chan(), rand_chan(), 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && tile_out.valid && tile_out.ready) begin
			tiles_seen++;
			if (tile_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected tile transaction at %0t", $time);
			end else if (tile_out.avg_blue !== tile_queue[0].blue ||
				tile_out.avg_green !== tile_queue[0].green ||
				tile_out.avg_red !== tile_queue[0].red ||
				tile_out.tile_column !== tile_queue[0].column ||
				tile_out.tile_row !== tile_queue[0].row ||
				tile_out.image_done !== tile_queue[0].done) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Tile mismatch: expected b%0d g%0d r%0d c%0d r%0d d%0d, %s",
						tile_queue[0].blue, tile_queue[0].green, tile_queue[0].red,
						tile_queue[0].column, tile_queue[0].row, tile_queue[0].done,
						$sformatf("got b%0d g%0d r%0d c%0d r%0d d%0d",
						tile_out.avg_blue, tile_out.avg_green, tile_out.avg_red,
						tile_out.tile_column, tile_out.tile_row, tile_out.image_done));
				void'(tile_queue.pop_front());
			end else begin
				void'(tile_queue.pop_front());
			end
		end
	end

	initial begin
		tile_out.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_on && $urandom_range(0, 5) == 0) begin
				tile_out.ready = 1'b0;
				repeat ($urandom_range(1, 5)) @(negedge clk);
			end
			tile_out.ready = 1'b1;
		end
	end

	initial begin
		int w;
		int h;
		int t;
		int n;
		int phase;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pixel_in.valid = 1'b0;
		pixel_in.pixel_blue = '0;
		pixel_in.pixel_green = '0;
		pixel_in.pixel_red = '0;
		mismatches = 0;
		pixels_sent = 0;
		tiles_seen = 0;
		frames_set = 0;
		stall_on = 1'b1;
		reg_width = 12'd640;
		reg_height = 12'd480;
		reg_tile = 7'd8;
		restart_frame();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < 10; i++) add_pix(rand_chan(), rand_chan(), rand_chan(), 1'b0, '0);
		add_cfg(RegImageWidth, 4);
		add_cfg(RegImageHeight, 2);
		add_cfg(RegTileSize, 1);
		add_pix(0, 0, 0, 1'b1, mk_tile(0, 0, 0, 0, 0, 0));
		add_pix(255, 255, 255, 1'b1, mk_tile(255, 255, 255, 1, 0, 0));
		add_pix(0, 255, 0, 1'b1, mk_tile(0, 255, 0, 2, 0, 0));
		add_pix(255, 0, 255, 1'b1, mk_tile(255, 0, 255, 3, 0, 0));
		add_pix(1, 2, 3, 1'b1, mk_tile(1, 2, 3, 0, 1, 0));
		add_pix(128, 64, 32, 1'b1, mk_tile(128, 64, 32, 1, 1, 0));
		add_pix(127, 254, 1, 1'b1, mk_tile(127, 254, 1, 2, 1, 0));
		add_pix(255, 255, 255, 1'b1, mk_tile(255, 255, 255, 3, 1, 1));
		add_cfg(RegUnused, 32'hFFFF_FFFF);
		add_cfg(RegTileSize, 64);
		add_cfg(RegImageWidth, 3);
		for (int i = 0; i < 5; i++) add_pix(255, 255, 255, 1'b0, '0);
		add_pix(255, 255, 255, 1'b1, mk_tile(255, 255, 255, 0, 0, 1));
		add_cfg(RegTileSize, 0);
		add_cfg(RegImageWidth, 0);
		add_cfg(RegImageHeight, 32'hFFFF_FFFF);
		for (int i = 0; i < 3; i++) add_pix(rand_chan(), rand_chan(), rand_chan(), 1'b0, '0);
		add_cfg(RegTileSize, 127);

		foreach (stim_table[i]) begin
			if (stim_table[i].kind == ROW_CFG) set_reg(stim_table[i].addr, stim_table[i].data);
			else send_pixel(stim_table[i].blue, stim_table[i].green, stim_table[i].red,
				stim_table[i].typed, stim_table[i].tile);
		end

		random_frame(MaxWidth, 1, MaxTile, 192, 1'b1);
		random_frame(1, MaxHeight, MaxTile, 192, 1'b0);
		random_frame(7, 5, 2, 70, 1'b1);
		phase = 0;
		while (pixels_sent < 800) begin
			w = $urandom_range(1, 24);
			h = $urandom_range(1, 12);
			case ($urandom_range(0, 5))
				0: t = 1;
				1: t = 64;
				2: t = 2;
				default: t = $urandom_range(1, 9);
			endcase
			n = w * h + $urandom_range(0, w * h);
			if (n > 800 - pixels_sent) n = 800 - pixels_sent;
			if (pixels_sent > 700) stall_on = 1'b0;
			random_frame(w, h, t, n, phase == 0);
			phase++;
		end
		stall_on = 1'b0;
		@(negedge clk);
		pixel_in.valid = 1'b0;
		while (tile_queue.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		$display("Sent %0d pixels over %0d register writes and checked %0d tiles,",
			pixels_sent, frames_set, tiles_seen);
		$display("covering unit, clamped, full-width and full-height tiles with stalls.");
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
